>>> src/mf3_pkg.sv
// Package for the 3x3 streaming median filter: shared types, constants and
// the lane control struct. No dependencies.
`default_nettype none
package mf3_pkg;
    localparam int PIX_W = 8;
    localparam int LANES = 4;
    localparam int WORD_W = PIX_W * LANES;
    localparam int ROWS_W = 13;
    localparam int CFGW_W = 9;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_ROWS = 4096;
    localparam logic [CFG_DATA_W-1:0] REG_ROW_WORDS = 13'd0;
    localparam logic [CFG_DATA_W-1:0] REG_FRAME_ROWS = 13'd1;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // Control carried alongside the lane stages into the merge stage.
    typedef struct packed {
        logic valid;
        logic last;
    } lane_ctl_t;

    function automatic logic [2*PIX_W-1:0] sort2(input pix_t a, input pix_t b);
        sort2 = (a > b) ? {a, b} : {b, a};
    endfunction
endpackage
`default_nettype wire

>>> src/mf3_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mf3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> src/mf3_lane.sv
// One median lane: median of nine pixels in three registered stages using
// the classic row-sort / column-select network. Depends on mf3_pkg.
`default_nettype none
module mf3_lane (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire mf3_pkg::pix_t [8:0] nb,
    output mf3_pkg::pix_t            med
);
    mf3_pkg::pix_t s_reg [9];
    mf3_pkg::pix_t s_next [9];
    mf3_pkg::pix_t m_reg [3];
    mf3_pkg::pix_t m_next [3];
    mf3_pkg::pix_t med_reg;
    mf3_pkg::pix_t med_next;

    // Sort each row of three; yields row min, mid, max.
    always_comb
    begin
        logic [15:0] t;
        mf3_pkg::pix_t a;
        mf3_pkg::pix_t b;
        mf3_pkg::pix_t c;
        for (int r = 0; r < 3; r++)
        begin
            t = mf3_pkg::sort2(nb[3*r], nb[3*r+1]);
            a = t[7:0];
            b = t[15:8];
            t = mf3_pkg::sort2(b, nb[3*r+2]);
            b = t[7:0];
            c = t[15:8];
            t = mf3_pkg::sort2(a, b);
            s_next[3*r]   = t[7:0];
            s_next[3*r+1] = t[15:8];
            s_next[3*r+2] = c;
        end
    end

    // Max of the mins, median of the mids, min of the maxes.
    always_comb
    begin
        mf3_pkg::pix_t x;
        mf3_pkg::pix_t y;
        mf3_pkg::pix_t z;
        x = (s_reg[0] > s_reg[3]) ? s_reg[0] : s_reg[3];
        m_next[0] = (x > s_reg[6]) ? x : s_reg[6];
        x = (s_reg[2] < s_reg[5]) ? s_reg[2] : s_reg[5];
        m_next[2] = (x < s_reg[8]) ? x : s_reg[8];
        x = (s_reg[1] < s_reg[4]) ? s_reg[1] : s_reg[4];
        y = (s_reg[1] < s_reg[4]) ? s_reg[4] : s_reg[1];
        z = (y < s_reg[7]) ? y : s_reg[7];
        m_next[1] = (x > z) ? x : z;
    end

    always_comb
    begin
        mf3_pkg::pix_t lo;
        mf3_pkg::pix_t hi;
        lo = (m_reg[0] < m_reg[1]) ? m_reg[0] : m_reg[1];
        hi = (m_reg[0] < m_reg[1]) ? m_reg[1] : m_reg[0];
        hi = (hi < m_reg[2]) ? hi : m_reg[2];
        med_next = (lo > hi) ? lo : hi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_next;
            m_reg   <= m_next;
            med_reg <= med_next;
        end
    end

    assign med = med_reg;
endmodule
`default_nettype wire

>>> src/mf3_merge.sv
// Merge stage: packs lane medians into a word and holds the result in an
// output register with a skid slot. Depends on mf3_pkg.
`default_nettype none
module mf3_merge (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mf3_pkg::pix_t [mf3_pkg::LANES-1:0] med,
    input  wire mf3_pkg::lane_ctl_t                 ctl,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [mf3_pkg::WORD_W-1:0]              out_word,
    output logic                                    out_last,
    output logic                                    full
);
    logic o_v_reg, o_v_next, s_v_reg, s_v_next;
    logic [mf3_pkg::WORD_W-1:0] o_w_reg, o_w_next, s_w_reg, s_w_next;
    logic o_l_reg, o_l_next, s_l_reg, s_l_next;
    logic [mf3_pkg::WORD_W-1:0] word;

    assign word = med;

    always_comb
    begin
        o_v_next = o_v_reg; o_w_next = o_w_reg; o_l_next = o_l_reg;
        s_v_next = s_v_reg; s_w_next = s_w_reg; s_l_next = s_l_reg;
        if (!o_v_reg || !out_stall)
        begin
            if (s_v_reg)
            begin
                o_v_next = 1'b1; o_w_next = s_w_reg; o_l_next = s_l_reg;
                s_v_next = ctl.valid; s_w_next = word; s_l_next = ctl.last;
            end
            else
            begin
                o_v_next = ctl.valid; o_w_next = word; o_l_next = ctl.last;
            end
        end
        else if (ctl.valid)
        begin
            s_v_next = 1'b1; s_w_next = word; s_l_next = ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= o_v_next;
            s_v_reg <= s_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_w_reg <= o_w_next; o_l_reg <= o_l_next;
        s_w_reg <= s_w_next; s_l_reg <= s_l_next;
    end

    assign out_valid = o_v_reg;
    assign out_word  = o_w_reg;
    assign out_last  = o_l_reg;
    assign full      = s_v_reg;
endmodule
`default_nettype wire

>>> src/median_filter_3x3_stream_core.sv
// Top level of the streaming 3x3 median filter: line stores, window,
// four median lanes and merge. Depends on mf3_pkg, mf3_ram, mf3_lane, mf3_merge.
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    opcode, pixel_word
//  out       output     out_valid/out_stall  filtered_word, frame_last
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// One word per clock sustained while the pipeline is not frozen; from input
// transfer to result transfer an item passes the line-store read, the three
// lane stages and the output register.
// The whole pipeline advances together; it freezes only when the skid
// slot of the output register is occupied and the output is stalled.
// Reset clears positions, window and control; line stores are not cleared.
`default_nettype none
module median_filter_3x3_stream_core #(
    parameter int MAX_ROW_WORDS = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               opcode,
    input  wire logic [31:0]                        pixel_word,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [31:0]                             filtered_word,
    output logic                                    frame_last,
    input  wire logic                               cfg_we,
    input  wire logic [0:0]                         cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int AW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int CW = $clog2(MAX_ROW_WORDS + 1);
    localparam int PW = mf3_pkg::PIX_W;

    logic [8:0]  rw_reg;
    logic [12:0] fr_reg;
    logic [CW-1:0] ew;
    logic [13:0] er;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg <= 9'd160;
            fr_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            if ({12'd0, cfg_index} == mf3_pkg::REG_ROW_WORDS)
                rw_reg <= cfg_data[8:0];
            else if ({12'd0, cfg_index} == mf3_pkg::REG_FRAME_ROWS)
                fr_reg <= cfg_data[12:0];
        end
    end

    always_comb
    begin
        if (rw_reg == 9'd0) ew = CW'(1);
        else if (32'(rw_reg) > MAX_ROW_WORDS) ew = CW'(MAX_ROW_WORDS);
        else ew = CW'(rw_reg);
        if (fr_reg == 13'd0) er = 14'd1;
        else if (32'(fr_reg) > mf3_pkg::MAX_ROWS) er = 14'(mf3_pkg::MAX_ROWS);
        else er = {1'b0, fr_reg};
    end

    logic en, full;
    logic acc;
    assign en = !(full && out_stall);
    assign in_stall = !en;
    assign acc = in_valid && en;

    // Stage 0: positions, line store read.
    logic [CW-1:0] c_reg, c_next, cu;
    logic [13:0] q_reg, q_next, qu;
    always_comb
    begin
        cu = c_reg; qu = q_reg;
        if (c_reg >= ew || q_reg > er + 14'd1 || (q_reg == er + 14'd1 && c_reg != '0))
        begin
            cu = '0; qu = '0;
        end
        if (cu == '0 && qu == er + 14'd1)
        begin
            c_next = '0; q_next = '0;
        end
        else if (cu + CW'(1) >= ew)
        begin
            c_next = '0; q_next = qu + 14'd1;
        end
        else
        begin
            c_next = cu + CW'(1); q_next = qu;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0; q_reg <= '0;
        end
        else if (acc)
        begin
            c_reg <= c_next; q_reg <= q_next;
        end
    end

    // Stage 1 holds the item while the line stores are read.
    logic s1_v_reg;
    logic [AW-1:0] s1_a_reg;
    logic s1_cz_reg, s1_top2_reg, s1_top1_reg, s1_emit_reg, s1_last_reg;
    logic [31:0] s1_fresh_reg;
    logic [31:0] old_rd, new_rd, f0, f1, newer_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_a_reg    <= AW'(cu);
            s1_cz_reg   <= (cu == '0);
            s1_top2_reg <= (qu >= 14'd2);
            s1_top1_reg <= (qu >= 14'd1);
            s1_emit_reg <= (cu != '0) ? (qu >= 14'd1) : (qu >= 14'd2);
            s1_last_reg <= (cu == '0) && (qu == er + 14'd1);
            s1_fresh_reg <= (opcode == mf3_pkg::OP_PIXEL && qu < er) ? pixel_word : 32'd0;
        end
    end

    // Older line takes newer's old value; newer takes the fresh word. Both
    // write in stage 1, after the read in stage 0 of the same address.
    mf3_ram #(.WIDTH(32), .DEPTH(MAX_ROW_WORDS)) u_older (
        .clk(clk), .we(s1_v_reg && en), .waddr(s1_a_reg), .wdata(newer_raw),
        .re(acc), .raddr(AW'(cu)), .rdata(old_rd)
    );
    mf3_ram #(.WIDTH(32), .DEPTH(MAX_ROW_WORDS)) u_newer (
        .clk(clk), .we(s1_v_reg && en), .waddr(s1_a_reg), .wdata(s1_fresh_reg),
        .re(acc), .raddr(AW'(cu)), .rdata(new_rd)
    );

    // Back-to-back access to the same word happens when the row is one word
    // wide or when a frame restarts, so bypass the store writes from stage 1.
    logic byp_reg;
    logic [31:0] byp_old_reg, byp_new_reg;
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            byp_reg     <= s1_v_reg && (s1_a_reg == AW'(cu));
            byp_old_reg <= newer_raw;
            byp_new_reg <= s1_fresh_reg;
        end
    end
    assign newer_raw = byp_reg ? byp_new_reg : new_rd;
    assign f0 = s1_top2_reg ? (byp_reg ? byp_old_reg : old_rd) : 32'd0;
    assign f1 = s1_top1_reg ? newer_raw : 32'd0;

    // Window and neighborhood formation.
    logic [39:0] win_reg [3];
    logic [31:0] fr [3];
    assign fr[0] = f0;
    assign fr[1] = f1;
    assign fr[2] = s1_fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++) win_reg[i] <= '0;
        end
        else if (s1_v_reg && en)
        begin
            for (int i = 0; i < 3; i++)
                win_reg[i] <= {s1_cz_reg ? 8'd0 : win_reg[i][31:24], fr[i]};
        end
    end

    mf3_pkg::pix_t [8:0] nb [mf3_pkg::LANES];
    always_comb
    begin
        logic [47:0] px;
        for (int p = 0; p < mf3_pkg::LANES; p++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                px = {s1_cz_reg ? 8'd0 : fr[i][7:0], win_reg[i][31:0], win_reg[i][39:32]};
                nb[p][3*i]   = px[PW*p +: PW];
                nb[p][3*i+1] = px[PW*(p+1) +: PW];
                nb[p][3*i+2] = px[PW*(p+2) +: PW];
            end
        end
    end

    mf3_pkg::pix_t [mf3_pkg::LANES-1:0] med;
    for (genvar g = 0; g < mf3_pkg::LANES; g++)
    begin : g_lane
        mf3_lane u_lane (.clk(clk), .en(en), .nb(nb[g]), .med(med[g]));
    end

    mf3_pkg::lane_ctl_t ctl_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++) ctl_reg[i] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= '{valid: s1_v_reg && s1_emit_reg, last: s1_last_reg};
            ctl_reg[1] <= ctl_reg[0];
            ctl_reg[2] <= ctl_reg[1];
        end
    end

    mf3_merge u_merge (
        .clk(clk), .rst_n(rst_n), .med(med),
        .ctl(en ? ctl_reg[2] : '0),
        .out_stall(out_stall), .out_valid(out_valid),
        .out_word(filtered_word), .out_last(frame_last), .full(full)
    );
endmodule
`default_nettype wire

>>> src/mf3_checker.sv
// Port-level checker for the median filter top level, bound to it below.
// Depends on median_filter_3x3_stream_core ports only.
`default_nettype none
module mf3_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] filtered_word,
    input wire logic        frame_last
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered_word) && $stable(frame_last))
        else $error("stalled result changed");
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled without pending result");
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result right after reset");
endmodule

bind median_filter_3x3_stream_core mf3_checker u_mf3_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_word(filtered_word), .frame_last(frame_last)
);
`default_nettype wire
